@@ design/i2cmsr_pkg.sv @@
`default_nettype none

package i2cmsr_pkg;

  // Register map
  localparam int unsigned CfgAddrW = 3;
  localparam logic [0:0] RegRecvCapacity = 1'b0;
  localparam logic [7:0] RecvCapacityReset = 8'd32;

  typedef enum logic [1:0] {
    REQ_SEND  = 2'd0,
    REQ_EVENT = 2'd1,
    REQ_ERROR = 2'd2,
    REQ_POLL  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    OUTC_NONE  = 2'd0,
    OUTC_SENT  = 2'd1,
    OUTC_NACK  = 2'd2,
    OUTC_ERROR = 2'd3
  } outcome_e;

  typedef struct packed {
    req_type_e  req_type;
    logic [6:0] dest_address;
    logic [7:0] send_length;
    logic       flag_addr;
    logic       flag_stop;
    logic       flag_nack;
    logic       flag_busy;
    logic       flag_arlo;
    logic       flag_berr;
    logic       flag_ovr;
    logic [7:0] rx_remaining;
  } event_t;

  typedef struct packed {
    logic       mst_on;
    logic       rty_due;
    logic [7:0] stored_address;
    logic [7:0] stored_length;
  } seq_state_t;

  typedef struct packed {
    logic sent;
    logic nack;
    logic error;
    logic retry;
  } cnt_inc_t;

  typedef struct packed {
    logic       launch_send;
    logic [7:0] launch_address;
    logic [7:0] launch_length;
    logic       send_done;
    outcome_e   send_outcome;
    logic       rx_arm;
    logic       rx_disable;
    logic       packet_ready;
    logic [7:0] packet_length;
    logic       bus_reset;
    logic       poll_schedule;
  } action_t;

endpackage

`default_nettype wire

@@ design/i2cmsr_cfg.sv @@
`default_nettype none

module i2cmsr_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [i2cmsr_pkg::CfgAddrW-1:0]   paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  output logic      [7:0]                        recv_capacity_o
);

  logic [7:0] recv_capacity_q, recv_capacity_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    recv_capacity_d = recv_capacity_q;
    if (wr_en && (paddr[2] == i2cmsr_pkg::RegRecvCapacity)) begin
      recv_capacity_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_capacity_q <= i2cmsr_pkg::RecvCapacityReset;
    end else begin
      recv_capacity_q <= recv_capacity_d;
    end
  end

  // Only one register; everything else reads as zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == i2cmsr_pkg::RegRecvCapacity) begin
      prdata = {24'd0, recv_capacity_q};
    end
  end

  assign recv_capacity_o = recv_capacity_q;

endmodule

`default_nettype wire

@@ design/i2cmsr_evt.sv @@
`default_nettype none

module i2cmsr_evt (
  input  wire i2cmsr_pkg::event_t     evt_i,
  input  wire i2cmsr_pkg::seq_state_t st_i,
  input  wire logic [7:0]             recv_capacity_i,
  output i2cmsr_pkg::seq_state_t      st_o,
  output i2cmsr_pkg::cnt_inc_t        inc_o,
  output i2cmsr_pkg::action_t         act_o
);

  logic handled;

  assign handled = evt_i.flag_berr || evt_i.flag_arlo || evt_i.flag_ovr;

  always_comb begin
    st_o  = st_i;
    inc_o = '0;
    act_o = '0;
    act_o.send_outcome = i2cmsr_pkg::OUTC_NONE;
    unique case (evt_i.req_type)
      i2cmsr_pkg::REQ_SEND: begin
        // ignored while a master write is in flight
        if (!st_i.mst_on) begin
          act_o.bus_reset      = evt_i.flag_busy;
          st_o.mst_on          = 1'b1;
          st_o.rty_due         = 1'b0;
          st_o.stored_address  = {evt_i.dest_address, 1'b0};
          st_o.stored_length   = evt_i.send_length;
          act_o.launch_send    = 1'b1;
          act_o.launch_address = {evt_i.dest_address, 1'b0};
          act_o.launch_length  = evt_i.send_length;
        end
      end
      i2cmsr_pkg::REQ_EVENT: begin
        // addressed as slave mid-send: we lost the bus, retry later
        if (evt_i.flag_addr && st_o.mst_on && !st_o.rty_due) begin
          st_o.rty_due        = 1'b1;
          inc_o.retry         = 1'b1;
          act_o.poll_schedule = 1'b1;
        end
        if (st_o.mst_on && !st_o.rty_due) begin
          if (evt_i.flag_stop) begin
            if (evt_i.flag_nack) begin
              inc_o.nack         = 1'b1;
              act_o.send_outcome = i2cmsr_pkg::OUTC_NACK;
            end else begin
              inc_o.sent         = 1'b1;
              act_o.send_outcome = i2cmsr_pkg::OUTC_SENT;
            end
            act_o.send_done = 1'b1;
            st_o.mst_on     = 1'b0;
          end
        end else if (evt_i.flag_addr) begin
          act_o.rx_arm = 1'b1;
        end else if (evt_i.flag_stop) begin
          act_o.rx_disable = 1'b1;
          if (evt_i.rx_remaining < recv_capacity_i) begin
            act_o.packet_ready  = 1'b1;
            act_o.packet_length = recv_capacity_i - evt_i.rx_remaining;
          end
        end
        if (st_o.rty_due && !evt_i.flag_busy) begin
          st_o.rty_due         = 1'b0;
          act_o.launch_send    = 1'b1;
          act_o.launch_address = st_i.stored_address;
          act_o.launch_length  = st_i.stored_length;
        end
      end
      i2cmsr_pkg::REQ_ERROR: begin
        act_o.bus_reset = evt_i.flag_berr;
        if (evt_i.flag_arlo && st_o.mst_on && !st_o.rty_due) begin
          st_o.rty_due        = 1'b1;
          inc_o.retry         = 1'b1;
          act_o.poll_schedule = 1'b1;
        end
        if (handled) begin
          if (st_o.mst_on && !st_o.rty_due) begin
            inc_o.error        = 1'b1;
            act_o.send_done    = 1'b1;
            act_o.send_outcome = i2cmsr_pkg::OUTC_ERROR;
            st_o.mst_on        = 1'b0;
          end else begin
            act_o.rx_disable = 1'b1;
          end
        end
      end
      i2cmsr_pkg::REQ_POLL: begin
        if (st_i.rty_due) begin
          if (evt_i.flag_busy) begin
            act_o.poll_schedule = 1'b1;
          end else begin
            st_o.rty_due         = 1'b0;
            act_o.launch_send    = 1'b1;
            act_o.launch_address = st_i.stored_address;
            act_o.launch_length  = st_i.stored_length;
          end
        end
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/i2c_multimaster_send_retry_ctrl_core.sv @@
// I2C multimaster send sequencer with transparent retry after lost arbitration.
// Input channel (in_valid_i / in_ready_o) carries one event per transfer: a
// send request, an event interrupt, an error interrupt or a retry poll tick,
// with its flags. Output channel (out_valid_o / out_ready_i) returns exactly
// one action set per event: launch, done with outcome, receive arm/disable,
// packet delivery, bus reset and poll scheduling.
// The event is decoded against the sequencer state in one combinational pass
// and the actions land in the output register at the same edge that updates
// the state. Throughput: one event per cycle while the output side keeps
// taking results, set by that single pass and the output register.
// Stall: while a result waits untaken, in_ready_o stays high only if the
// result is taken in that same cycle; otherwise the event is held off.
// Reset clears the sequencer flags, stored address/length, the four 32-bit
// statistics counters, and the output valid; recv_capacity returns to 32.
// recv_capacity sits at APB byte address 0 and should be written only while
// the block is idle.
`default_nettype none

module i2c_multimaster_send_retry_ctrl_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // config
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [i2cmsr_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  // event in
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      req_type_i,
  input  wire logic [6:0]                      dest_address_i,
  input  wire logic [7:0]                      send_length_i,
  input  wire logic                            flag_addr_i,
  input  wire logic                            flag_stop_i,
  input  wire logic                            flag_nack_i,
  input  wire logic                            flag_busy_i,
  input  wire logic                            flag_arlo_i,
  input  wire logic                            flag_berr_i,
  input  wire logic                            flag_ovr_i,
  input  wire logic [7:0]                      rx_remaining_i,
  // actions out
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 launch_send_o,
  output logic      [7:0]                      launch_address_o,
  output logic      [7:0]                      launch_length_o,
  output logic                                 send_done_o,
  output logic      [1:0]                      send_outcome_o,
  output logic                                 rx_arm_o,
  output logic                                 rx_disable_o,
  output logic                                 packet_ready_o,
  output logic      [7:0]                      packet_length_o,
  output logic                                 bus_reset_o,
  output logic                                 poll_schedule_o
);

  logic [7:0] recv_capacity;

  i2cmsr_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .recv_capacity_o (recv_capacity)
  );

  i2cmsr_pkg::event_t     evt;
  i2cmsr_pkg::seq_state_t st_q, st_d, st_next;
  i2cmsr_pkg::cnt_inc_t   inc;
  i2cmsr_pkg::action_t    act, out_q, out_d;
  logic                   out_valid_q, out_valid_d;
  logic                   in_xfer;

  // statistics, wrap freely
  logic [31:0] sent_count_q, sent_count_d;
  logic [31:0] nack_count_q, nack_count_d;
  logic [31:0] error_count_q, error_count_d;
  logic [31:0] retry_count_q, retry_count_d;

  assign evt.req_type     = i2cmsr_pkg::req_type_e'(req_type_i);
  assign evt.dest_address = dest_address_i;
  assign evt.send_length  = send_length_i;
  assign evt.flag_addr    = flag_addr_i;
  assign evt.flag_stop    = flag_stop_i;
  assign evt.flag_nack    = flag_nack_i;
  assign evt.flag_busy    = flag_busy_i;
  assign evt.flag_arlo    = flag_arlo_i;
  assign evt.flag_berr    = flag_berr_i;
  assign evt.flag_ovr     = flag_ovr_i;
  assign evt.rx_remaining = rx_remaining_i;

  i2cmsr_evt u_evt (
    .evt_i           (evt),
    .st_i            (st_q),
    .recv_capacity_i (recv_capacity),
    .st_o            (st_next),
    .inc_o           (inc),
    .act_o           (act)
  );

  // accept when the result slot is empty or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    st_d          = st_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    sent_count_d  = sent_count_q;
    nack_count_d  = nack_count_q;
    error_count_d = error_count_q;
    retry_count_d = retry_count_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_xfer) begin
      st_d          = st_next;
      out_d         = act;
      out_valid_d   = 1'b1;
      sent_count_d  = sent_count_q + {31'd0, inc.sent};
      nack_count_d  = nack_count_q + {31'd0, inc.nack};
      error_count_d = error_count_q + {31'd0, inc.error};
      retry_count_d = retry_count_q + {31'd0, inc.retry};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= '0;
      out_valid_q   <= 1'b0;
      sent_count_q  <= '0;
      nack_count_q  <= '0;
      error_count_q <= '0;
      retry_count_q <= '0;
    end else begin
      st_q          <= st_d;
      out_valid_q   <= out_valid_d;
      sent_count_q  <= sent_count_d;
      nack_count_q  <= nack_count_d;
      error_count_q <= error_count_d;
      retry_count_q <= retry_count_d;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign launch_send_o    = out_q.launch_send;
  assign launch_address_o = out_q.launch_address;
  assign launch_length_o  = out_q.launch_length;
  assign send_done_o      = out_q.send_done;
  assign send_outcome_o   = out_q.send_outcome;
  assign rx_arm_o         = out_q.rx_arm;
  assign rx_disable_o     = out_q.rx_disable;
  assign packet_ready_o   = out_q.packet_ready;
  assign packet_length_o  = out_q.packet_length;
  assign bus_reset_o      = out_q.bus_reset;
  assign poll_schedule_o  = out_q.poll_schedule;

  // a finished send always reports a real outcome
  a_done_has_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && send_done_o) |-> (send_outcome_o != i2cmsr_pkg::OUTC_NONE))
    else $error("send_done without outcome");

  // a delivered packet is never empty
  a_packet_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && packet_ready_o) |-> (packet_length_o != 8'd0))
    else $error("empty packet delivered");

  // accepted send on an idle master leaves the master active with a launch
  a_send_launches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (req_type_i == i2cmsr_pkg::REQ_SEND) && !st_q.mst_on)
    |=> (st_q.mst_on && out_valid_o && launch_send_o && !launch_address_o[0]))
    else $error("send request did not launch");

  // a retry relaunch replays the stored address and length
  a_retry_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (req_type_i == i2cmsr_pkg::REQ_POLL) && st_q.rty_due
     && !flag_busy_i)
    |=> (launch_send_o && (launch_address_o == $past(st_q.stored_address))
         && (launch_length_o == $past(st_q.stored_length)) && !st_q.rty_due))
    else $error("retry relaunch mismatch");

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // Flag bits in the order {addr, stop, nack, busy, arlo, berr, ovr}
  localparam logic [6:0] FlagAddr = 7'h40;
  localparam logic [6:0] FlagStop = 7'h20;
  localparam logic [6:0] FlagNack = 7'h10;
  localparam logic [6:0] FlagBusy = 7'h08;
  localparam logic [6:0] FlagArlo = 7'h04;
  localparam logic [6:0] FlagBerr = 7'h02;
  localparam logic [6:0] FlagOvr  = 7'h01;
  localparam logic [6:0] FlagAll  = 7'h7F;

  localparam int unsigned AddrW = i2cmsr_pkg::CfgAddrW;
  localparam logic [AddrW-1:0] CapAddr = AddrW'(4 * i2cmsr_pkg::RegRecvCapacity);
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Configuration port
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  // Event side: the whole event is driven as one packed word
  logic               in_valid = 1'b0;
  logic               in_ready;
  i2cmsr_pkg::event_t ev_drv = '0;

  // Action side
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       launch_send;
  logic [7:0] launch_address;
  logic [7:0] launch_length;
  logic       send_done;
  logic [1:0] send_outcome;
  logic       rx_arm;
  logic       rx_disable;
  logic       packet_ready;
  logic [7:0] packet_length;
  logic       bus_reset;
  logic       poll_schedule;

  i2c_multimaster_send_retry_ctrl_core u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .req_type_i       (ev_drv.req_type),
    .dest_address_i   (ev_drv.dest_address),
    .send_length_i    (ev_drv.send_length),
    .flag_addr_i      (ev_drv.flag_addr),
    .flag_stop_i      (ev_drv.flag_stop),
    .flag_nack_i      (ev_drv.flag_nack),
    .flag_busy_i      (ev_drv.flag_busy),
    .flag_arlo_i      (ev_drv.flag_arlo),
    .flag_berr_i      (ev_drv.flag_berr),
    .flag_ovr_i       (ev_drv.flag_ovr),
    .rx_remaining_i   (ev_drv.rx_remaining),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .launch_send_o    (launch_send),
    .launch_address_o (launch_address),
    .launch_length_o  (launch_length),
    .send_done_o      (send_done),
    .send_outcome_o   (send_outcome),
    .rx_arm_o         (rx_arm),
    .rx_disable_o     (rx_disable),
    .packet_ready_o   (packet_ready),
    .packet_length_o  (packet_length),
    .bus_reset_o      (bus_reset),
    .poll_schedule_o  (poll_schedule)
  );

  // Sequencer shadow, advanced in transfer order on the event side
  logic        mst_active = 1'b0;
  logic        retry_pend = 1'b0;
  logic [7:0]  addr_q = '0;
  logic [7:0]  len_q = '0;
  logic [7:0]  rx_cap = i2cmsr_pkg::RecvCapacityReset;
  int unsigned sent_cnt = 0;
  int unsigned nack_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned retry_cnt = 0;

  i2cmsr_pkg::action_t action_q[$];  // action sets still owed by the block
  int unsigned mismatches = 0;
  int unsigned useful_items = 0; // events taken, ignored send requests excluded
  int unsigned results_seen = 0;
  int unsigned packets_seen = 0;
  int unsigned cycle_cnt = 0;
  logic [7:0]  mid_cap = 8'd100;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req = 1'b0;

  initial forever #1 clk = ~clk;

  // Expected action set for one event; updates the shadow state as it goes.
  function automatic i2cmsr_pkg::action_t predict_actions(i2cmsr_pkg::event_t e);
    i2cmsr_pkg::action_t a;
    a = '0;
    unique case (e.req_type)
      i2cmsr_pkg::REQ_SEND: begin
        // A send while the master is active (retry pending or not) is dropped
        if (!mst_active) begin
          a.bus_reset = e.flag_busy;   // wait deadline expired: recover bus first
          mst_active = 1'b1;
          retry_pend = 1'b0;
          addr_q = {e.dest_address, 1'b0};
          len_q = e.send_length;
          a.launch_send = 1'b1;
          a.launch_address = addr_q;
          a.launch_length = len_q;
        end
      end
      i2cmsr_pkg::REQ_EVENT: begin
        // Addressed as slave mid-send: we lost the bus, retry later
        if (e.flag_addr && mst_active && !retry_pend) begin
          retry_pend = 1'b1;
          retry_cnt++;
          a.poll_schedule = 1'b1;
        end
        if (mst_active && !retry_pend) begin
          if (e.flag_stop) begin
            if (e.flag_nack) begin
              nack_cnt++;
              a.send_outcome = i2cmsr_pkg::OUTC_NACK;
            end else begin
              sent_cnt++;
              a.send_outcome = i2cmsr_pkg::OUTC_SENT;
            end
            a.send_done = 1'b1;
            mst_active = 1'b0;
          end
        end else if (e.flag_addr) begin
          a.rx_arm = 1'b1;
        end else if (e.flag_stop) begin
          a.rx_disable = 1'b1;
          // remaining at or above capacity delivers no packet at all
          if (e.rx_remaining < rx_cap) begin
            a.packet_ready = 1'b1;
            a.packet_length = rx_cap - e.rx_remaining;
          end
        end
        if (retry_pend && !e.flag_busy) begin
          retry_pend = 1'b0;
          a.launch_send = 1'b1;
          a.launch_address = addr_q;
          a.launch_length = len_q;
        end
      end
      i2cmsr_pkg::REQ_ERROR: begin
        a.bus_reset = e.flag_berr;
        if (e.flag_arlo && mst_active && !retry_pend) begin
          retry_pend = 1'b1;
          retry_cnt++;
          a.poll_schedule = 1'b1;
        end
        // no error flag at all: nothing happens
        if (e.flag_berr || e.flag_arlo || e.flag_ovr) begin
          if (mst_active && !retry_pend) begin
            err_cnt++;
            a.send_done = 1'b1;
            a.send_outcome = i2cmsr_pkg::OUTC_ERROR;
            mst_active = 1'b0;
          end else begin
            a.rx_disable = 1'b1;
          end
        end
      end
      default: begin
        // Poll tick: relaunch once the bus is idle, else poll again
        if (retry_pend) begin
          if (e.flag_busy) begin
            a.poll_schedule = 1'b1;
          end else begin
            retry_pend = 1'b0;
            a.launch_send = 1'b1;
            a.launch_address = addr_q;
            a.launch_length = len_q;
          end
        end
      end
    endcase
    return a;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] seen);
    if (want !== seen) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s, action set %0d: expected %0h, got %0h",
                 what, results_seen, want, seen);
    end
  endtask

  // Scoreboard: retire the action set taken at this edge, then queue the
  // prediction for the event taken at this edge (latency rules out overlap).
  always @(posedge clk) begin : scoreboard
    i2cmsr_pkg::action_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (action_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("action set %0d arrived with nothing outstanding", results_seen);
        end else begin
          want = action_q.pop_front();
          check_field("launch_send", {7'd0, want.launch_send}, {7'd0, launch_send});
          check_field("launch_address", want.launch_address, launch_address);
          check_field("launch_length", want.launch_length, launch_length);
          check_field("send_done", {7'd0, want.send_done}, {7'd0, send_done});
          check_field("send_outcome", {6'd0, want.send_outcome}, {6'd0, send_outcome});
          check_field("rx_arm", {7'd0, want.rx_arm}, {7'd0, rx_arm});
          check_field("rx_disable", {7'd0, want.rx_disable}, {7'd0, rx_disable});
          check_field("packet_ready", {7'd0, want.packet_ready}, {7'd0, packet_ready});
          check_field("packet_length", want.packet_length, packet_length);
          check_field("bus_reset", {7'd0, want.bus_reset}, {7'd0, bus_reset});
          check_field("poll_schedule", {7'd0, want.poll_schedule},
                      {7'd0, poll_schedule});
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        if (!(ev_drv.req_type == i2cmsr_pkg::REQ_SEND && mst_active))
          useful_items++;
        want = predict_actions(ev_drv);
        if (want.packet_ready)
          packets_seen++;
        action_q.push_back(want);
      end
    end
  end

  // Action-side ready: random stall bursts, or one long hold-off on request
  initial begin : sink
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d action sets outstanding",
               cycle_cnt, action_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One transfer on the event side; valid held until taken.
  task automatic send_event(input i2cmsr_pkg::event_t e);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    ev_drv <= e;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender stops and waits until every owed action set has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (action_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // APB transfer on the capacity register; ends with the bus released.
  task automatic apb_xfer(input bit is_write, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= CapAddr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_capacity(input logic [7:0] cap);
    logic [31:0] rd;
    wait_drained();
    apb_xfer(1'b1, {24'd0, cap}, rd);
    rx_cap = cap;
    apb_xfer(1'b0, '0, rd);
    check_field("recv_capacity readback", cap, rd[7:0]);
  endtask

  function automatic i2cmsr_pkg::event_t mk_event(i2cmsr_pkg::req_type_e t,
                                                  logic [6:0] flags,
                                                  logic [6:0] da = '0,
                                                  logic [7:0] sl = '0,
                                                  logic [7:0] rem = '0);
    i2cmsr_pkg::event_t e;
    e.req_type = t;
    e.dest_address = da;
    e.send_length = sl;
    {e.flag_addr, e.flag_stop, e.flag_nack, e.flag_busy,
     e.flag_arlo, e.flag_berr, e.flag_ovr} = flags;
    e.rx_remaining = rem;
    return e;
  endfunction

  function automatic logic [6:0] some_of(logic [6:0] mask);
    return mask & 7'($urandom());
  endfunction

  // Random content, chosen type and flags; remaining leans on the capacity edge
  function automatic i2cmsr_pkg::event_t shaped(i2cmsr_pkg::req_type_e t,
                                                logic [6:0] flags);
    i2cmsr_pkg::event_t e;
    e = i2cmsr_pkg::event_t'($urandom());
    e.req_type = t;
    {e.flag_addr, e.flag_stop, e.flag_nack, e.flag_busy,
     e.flag_arlo, e.flag_berr, e.flag_ovr} = flags;
    case ($urandom_range(0, 3))
      0: e.rx_remaining = rx_cap;
      1: e.rx_remaining = rx_cap - 8'd1;
      2: e.rx_remaining = '0;
      default: ;
    endcase
    return e;
  endfunction

  // One short protocol sequence; mostly well formed, some noise.
  task automatic play_scenario();
    int k;
    logic [6:0] err_bit;
    err_bit = FlagOvr << $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      0, 1: begin  // plain send, then stop with or without nack
        send_event(shaped(i2cmsr_pkg::REQ_SEND, some_of(FlagAll)));
        send_event(shaped(i2cmsr_pkg::REQ_EVENT, FlagStop | some_of(~FlagAddr)));
      end
      2: begin  // send failed by an error interrupt, arlo turning into a retry
        send_event(shaped(i2cmsr_pkg::REQ_SEND, some_of(FlagAll)));
        send_event(shaped(i2cmsr_pkg::REQ_ERROR, err_bit | some_of(FlagAll)));
        send_event(shaped(i2cmsr_pkg::REQ_POLL, some_of(~FlagBusy)));
        send_event(shaped(i2cmsr_pkg::REQ_EVENT, FlagStop | some_of(FlagNack)));
      end
      3, 4: begin  // addressed as slave mid-send, polls on a busy bus, relaunch
        send_event(shaped(i2cmsr_pkg::REQ_SEND, some_of(FlagAll)));
        send_event(shaped(i2cmsr_pkg::REQ_EVENT,
                          FlagAddr | some_of(FlagStop | FlagNack | FlagBusy)));
        k = $urandom_range(0, 3);
        repeat (k) send_event(shaped(i2cmsr_pkg::REQ_POLL, FlagBusy | some_of(FlagAll)));
        send_event(shaped($urandom_range(0, 1) ? i2cmsr_pkg::REQ_POLL
                                               : i2cmsr_pkg::REQ_EVENT,
                          some_of(FlagStop | FlagNack | FlagArlo | FlagBerr | FlagOvr)));
        send_event(shaped(i2cmsr_pkg::REQ_EVENT, FlagStop | some_of(FlagNack)));
      end
      5: begin  // slave receive: arm, then stop with a packet
        send_event(shaped(i2cmsr_pkg::REQ_EVENT, FlagAddr | some_of(FlagBusy | FlagNack)));
        send_event(shaped(i2cmsr_pkg::REQ_EVENT,
                          FlagStop | some_of(FlagBusy | FlagNack | FlagArlo)));
      end
      6: begin  // second send while the first is in flight
        send_event(shaped(i2cmsr_pkg::REQ_SEND, some_of(FlagAll)));
        send_event(shaped(i2cmsr_pkg::REQ_SEND, some_of(FlagAll)));
        send_event(shaped(i2cmsr_pkg::REQ_EVENT, FlagStop | some_of(FlagNack | FlagBusy)));
      end
      7: begin  // error without error flags, poll with nothing pending
        send_event(shaped(i2cmsr_pkg::REQ_ERROR,
                          some_of(FlagAddr | FlagStop | FlagNack | FlagBusy)));
        send_event(shaped(i2cmsr_pkg::REQ_POLL, some_of(FlagAll)));
      end
      default: repeat ($urandom_range(1, 4)) send_event(i2cmsr_pkg::event_t'($urandom()));
    endcase
  endtask

  task automatic run_traffic(input int unsigned n);
    int unsigned target;
    target = useful_items + n;
    while (useful_items < target) play_scenario();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_reset_value();
    logic [31:0] rd;
    apb_xfer(1'b0, '0, rd);
    check_field("recv_capacity after reset", i2cmsr_pkg::RecvCapacityReset, rd[7:0]);
  endtask

  // Hand-picked events at the reset capacity of 32
  task automatic test_directed_cases();
    // nothing pending: poll ticks and a flagless error do nothing
    send_event(mk_event(i2cmsr_pkg::REQ_POLL, FlagBusy));
    send_event(mk_event(i2cmsr_pkg::REQ_POLL, '0));
    send_event(mk_event(i2cmsr_pkg::REQ_ERROR, FlagAddr | FlagStop | FlagNack | FlagBusy));
    // slave receive: arm, then stops with remaining at 0, 32, 255, 31
    send_event(mk_event(i2cmsr_pkg::REQ_EVENT, FlagAddr));
    send_event(mk_event(i2cmsr_pkg::REQ_EVENT, FlagStop, '0, '0, 8'd0));
    send_event(mk_event(i2cmsr_pkg::REQ_EVENT, FlagStop, '0, '0, 8'd32));
    send_event(mk_event(i2cmsr_pkg::REQ_EVENT, FlagStop, '0, '0, 8'd255));
    send_event(mk_event(i2cmsr_pkg::REQ_EVENT, FlagStop, '0, '0, 8'd31));
    send_event(mk_event(i2cmsr_pkg::REQ_ERROR, FlagBerr));
    // send on a busy bus at the field maxima, a dropped send, then sent
    send_event(mk_event(i2cmsr_pkg::REQ_SEND, FlagBusy, 7'h7F, 8'hFF));
    send_event(mk_event(i2cmsr_pkg::REQ_SEND, '0, 7'h55, 8'h0F));
    send_event(mk_event(i2cmsr_pkg::REQ_EVENT, FlagStop));
    // minimum address and length, nacked
    send_event(mk_event(i2cmsr_pkg::REQ_SEND, '0, 7'h00, 8'h00));
    send_event(mk_event(i2cmsr_pkg::REQ_EVENT, FlagStop | FlagNack));
    // bus error ends the send
    send_event(mk_event(i2cmsr_pkg::REQ_SEND, '0, 7'h2A, 8'h01));
    send_event(mk_event(i2cmsr_pkg::REQ_ERROR, FlagBerr));
    // lost to a slave address on a busy bus; send during the retry is dropped
    send_event(mk_event(i2cmsr_pkg::REQ_SEND, '0, 7'h11, 8'h80));
    send_event(mk_event(i2cmsr_pkg::REQ_EVENT, FlagAddr | FlagBusy));
    send_event(mk_event(i2cmsr_pkg::REQ_SEND, '0, 7'h22, 8'h44));
    send_event(mk_event(i2cmsr_pkg::REQ_POLL, FlagBusy));
    send_event(mk_event(i2cmsr_pkg::REQ_EVENT, FlagStop, '0, '0, 8'd8));
    send_event(mk_event(i2cmsr_pkg::REQ_EVENT, FlagStop));
    // arbitration lost via error interrupt, poll relaunches, overrun ends it
    send_event(mk_event(i2cmsr_pkg::REQ_SEND, FlagBusy, 7'h40, 8'h7F));
    send_event(mk_event(i2cmsr_pkg::REQ_ERROR, FlagArlo | FlagOvr));
    send_event(mk_event(i2cmsr_pkg::REQ_POLL, '0));
    send_event(mk_event(i2cmsr_pkg::REQ_ERROR, FlagOvr));
  endtask

  task automatic test_mixed_traffic();
    run_traffic(200);
  endtask

  // Smallest and largest receive buffer
  task automatic test_capacity_extremes();
    set_capacity(8'd1);
    run_traffic(150);
    set_capacity(8'd255);
    run_traffic(150);
  endtask

  // Action side held off for a long stretch while events keep coming, so the
  // output register fills and the event side stalls; then a full drain.
  task automatic test_output_holdoff();
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    run_traffic(40);
    wait_drained();
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_capacity();
    mid_cap = 8'($urandom_range(2, 254));
    set_capacity(mid_cap);
    run_traffic(120);
  endtask

  // Closing stretch at one transfer per cycle on both sides
  task automatic test_full_rate();
    set_capacity(8'd200);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_traffic(150);
  endtask

  initial begin : main
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_value();
    test_directed_cases();
    test_mixed_traffic();
    test_capacity_extremes();
    test_output_holdoff();
    test_random_capacity();
    test_full_rate();
    wait_drained();
    if (action_q.size() != 0) begin
      $display("%0d action sets never arrived", action_q.size());
      mismatches += action_q.size();
    end
    $display("Covered %0d events and %0d action sets, capacities 32, 1, 255, %0d, 200,",
             useful_items, results_seen, mid_cap);
    $display("long output hold-off; %0d sent, %0d nacked, %0d errors, %0d retries, %0d packets",
             sent_cnt, nack_cnt, err_cnt, retry_cnt, packets_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
